// ===== hdl/pde_pkg.sv =====
// ----------------------------------------------------------------------------
// pde_pkg: shared types and constants of the percent escape decoder
// Item payloads, escape phase codes, character codes and the decode result.
// ----------------------------------------------------------------------------
package pde_pkg;

    localparam int unsigned BUF_DEPTH = 6;
    localparam int unsigned CNT_W     = 3;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_ZERO    = 8'h30;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_PCT  = 2'd1,
        PH_HELD = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out;

    typedef struct packed {
        logic [BUF_DEPTH-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
        t_phase                    phase;
        logic [7:0]                held;
    } t_dec;

endpackage

// ===== hdl/percent_escape_decoder_top.sv =====
// ----------------------------------------------------------------------------
// percent_escape_decoder_top: streaming percent escape decoder
// Decodes %XX escapes in a byte stream, raw or as decimal numeric entities.
// ----------------------------------------------------------------------------
// An input item (byte plus last marker) is taken into an input register and
// decoded in one pass into a result buffer of up to six bytes, which drains
// one output item per cycle while the output is not stalled, so plain text
// flows at one item per cycle then; an item that yields several bytes holds
// the output port until all are taken (an entity such as "&#255;" yields six),
// and the buffer drain sets the input rate then. The input register takes the
// next item while the buffer still drains. Write the entity_mode register only
// while the stream is idle; the block itself does not enforce it.
module percent_escape_decoder_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_wr_en,
    input  logic           i_cfg_wr_data,
    input  logic           i_valid,
    output logic           o_stall,
    input  pde_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_stall,
    output pde_pkg::t_out  o_data
);

    logic                                        r_entity;
    pde_pkg::t_phase                             r_phase;
    logic [7:0]                                  r_held;
    pde_pkg::t_in                                r_in;
    logic                                        r_in_vld;
    logic [pde_pkg::BUF_DEPTH-1:0][7:0]          r_buf;
    logic [pde_pkg::CNT_W-1:0]                   r_cnt;
    logic [pde_pkg::CNT_W-1:0]                   r_idx;
    logic                                        r_last;

    pde_pkg::t_dec                               dec;
    logic                                        take;
    logic                                        done;
    logic                                        can_load;
    logic                                        load;
    logic                                        accept_in;
    logic                                        at_end;

    pde_decode u_decode (
        .i_byte   (r_in.in_byte),
        .i_last   (r_in.in_last),
        .i_entity (r_entity),
        .i_phase  (r_phase),
        .i_held   (r_held),
        .o_dec    (dec)
    );

    assign at_end    = (r_idx == r_cnt - 3'd1);
    assign o_valid   = (r_cnt != '0);
    assign take      = o_valid && !i_stall;
    assign done      = take && at_end;
    assign can_load  = (r_cnt == '0) || done;
    assign load      = r_in_vld && can_load;
    assign o_stall   = r_in_vld && !can_load;
    assign accept_in = i_valid && !o_stall;

    assign o_data.out_byte = r_buf[r_idx];
    assign o_data.out_last = r_last && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entity <= 1'b0;
            r_phase  <= pde_pkg::PH_IDLE;
            r_held   <= 8'd0;
            r_in_vld <= 1'b0;
            r_cnt    <= '0;
            r_idx    <= '0;
            r_last   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_entity <= i_cfg_wr_data;
            end
            if (accept_in) begin
                r_in     <= i_data;
                r_in_vld <= 1'b1;
            end else if (load) begin
                r_in_vld <= 1'b0;
            end
            if (load) begin
                r_buf   <= dec.bytes;
                r_cnt   <= dec.count;
                r_idx   <= '0;
                r_last  <= r_in.in_last;
                r_phase <= dec.phase;
                r_held  <= dec.held;
            end else if (take) begin
                // drop the buffer after its final byte, else advance
                if (at_end) begin
                    r_cnt <= '0;
                end else begin
                    r_idx <= r_idx + 3'd1;
                end
            end
        end
    end

`ifndef SYNTH
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_idx < r_cnt))
        else $error("result index beyond buffered count");

    a_last_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && r_in.in_last |-> (dec.count != '0))
        else $error("last item produced no result");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load && r_in.in_last |=> (r_phase == pde_pkg::PH_IDLE) && (r_held == 8'd0))
        else $error("escape state not cleared at end of string");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(pde_pkg::BUF_DEPTH))
        else $error("result buffer count overflow");
`endif

endmodule

// ===== hdl/pde_decode.sv =====
// ----------------------------------------------------------------------------
// pde_decode: one-item decode step
// Maps one input byte and the escape state to the list of output bytes and
// the next escape state.
// ----------------------------------------------------------------------------
module pde_decode (
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    input  logic            i_entity,
    input  pde_pkg::t_phase i_phase,
    input  logic [7:0]      i_held,
    output pde_pkg::t_dec   o_dec
);

    logic                       held_hex;
    logic                       byte_hex;
    logic [3:0]                 held_dig;
    logic [3:0]                 byte_dig;
    logic [7:0]                 value;
    logic [1:0]                 hund;
    logic [6:0]                 rem;
    logic [3:0]                 tens;
    logic [3:0]                 units;

    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

    assign {held_hex, held_dig} = hex_decode(i_held);
    assign {byte_hex, byte_dig} = hex_decode(i_byte);

    always_comb begin
        case ({held_hex, byte_hex})
            2'b11:   value = {held_dig, byte_dig};
            2'b10:   value = {4'd0, held_dig};
            2'b01:   value = {4'd0, byte_dig};
            default: value = 8'd0;
        endcase
    end

    // decimal digits of the decoded value
    always_comb begin
        if (value >= 8'd200) begin
            hund = 2'd2;
        end else if (value >= 8'd100) begin
            hund = 2'd1;
        end else begin
            hund = 2'd0;
        end
        rem  = 7'(value - 8'(hund) * 8'd100);
        tens = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (rem >= 7'(10 * k)) begin
                tens = 4'(k);
            end
        end
        units = 4'(rem - 7'(tens) * 7'd10);
    end

    always_comb begin
        o_dec       = '0;
        o_dec.phase = i_phase;
        o_dec.held  = i_held;
        case (i_phase)
            pde_pkg::PH_PCT: begin
                o_dec.held  = i_byte;
                o_dec.phase = pde_pkg::PH_HELD;
            end
            pde_pkg::PH_HELD: begin
                o_dec.phase = pde_pkg::PH_IDLE;
                if (value != 8'd0) begin
                    if (!i_entity || value == pde_pkg::CH_MINUS ||
                        value == pde_pkg::CH_COMMA || value == pde_pkg::CH_HASH) begin
                        o_dec.bytes[o_dec.count] = value;
                        o_dec.count = o_dec.count + 3'd1;
                    end else begin
                        o_dec.bytes[o_dec.count] = pde_pkg::CH_AMP;
                        o_dec.count = o_dec.count + 3'd1;
                        o_dec.bytes[o_dec.count] = pde_pkg::CH_HASH;
                        o_dec.count = o_dec.count + 3'd1;
                        if (value >= 8'd100) begin
                            o_dec.bytes[o_dec.count] = pde_pkg::CH_ZERO + 8'(hund);
                            o_dec.count = o_dec.count + 3'd1;
                        end
                        if (value >= 8'd10) begin
                            o_dec.bytes[o_dec.count] = pde_pkg::CH_ZERO + 8'(tens);
                            o_dec.count = o_dec.count + 3'd1;
                        end
                        o_dec.bytes[o_dec.count] = pde_pkg::CH_ZERO + 8'(units);
                        o_dec.count = o_dec.count + 3'd1;
                        o_dec.bytes[o_dec.count] = pde_pkg::CH_SEMI;
                        o_dec.count = o_dec.count + 3'd1;
                    end
                end else begin
                    // zero value: emit '%' and rescan the held bytes
                    o_dec.bytes[o_dec.count] = pde_pkg::CH_PERCENT;
                    o_dec.count = o_dec.count + 3'd1;
                    if (i_held == pde_pkg::CH_PERCENT) begin
                        o_dec.held  = i_byte;
                        o_dec.phase = pde_pkg::PH_HELD;
                    end else begin
                        o_dec.bytes[o_dec.count] = i_held;
                        o_dec.count = o_dec.count + 3'd1;
                        if (i_byte == pde_pkg::CH_PERCENT) begin
                            o_dec.phase = pde_pkg::PH_PCT;
                        end else begin
                            o_dec.bytes[o_dec.count] = i_byte;
                            o_dec.count = o_dec.count + 3'd1;
                        end
                    end
                end
            end
            default: begin
                o_dec.phase = pde_pkg::PH_IDLE;
                if (i_byte == pde_pkg::CH_PERCENT) begin
                    o_dec.phase = pde_pkg::PH_PCT;
                end else begin
                    o_dec.bytes[o_dec.count] = i_byte;
                    o_dec.count = o_dec.count + 3'd1;
                end
            end
        endcase

        // flush an unfinished escape at end of string
        if (i_last) begin
            if (o_dec.phase == pde_pkg::PH_PCT) begin
                o_dec.bytes[o_dec.count] = pde_pkg::CH_PERCENT;
                o_dec.count = o_dec.count + 3'd1;
            end else if (o_dec.phase == pde_pkg::PH_HELD) begin
                o_dec.bytes[o_dec.count] = pde_pkg::CH_PERCENT;
                o_dec.count = o_dec.count + 3'd1;
                o_dec.bytes[o_dec.count] = o_dec.held;
                o_dec.count = o_dec.count + 3'd1;
            end
            o_dec.phase = pde_pkg::PH_IDLE;
            o_dec.held  = 8'd0;
        end
    end

endmodule

// ===== verif/pde_stream_checker.sv =====
// ----------------------------------------------------------------------------
// pde_stream_checker: decoded-text predictor and scoreboard
// Watches the config port and both item channels of the percent escape
// decoder. It decodes each accepted input item on its own copy of the escape
// state and compares every output item with the oldest predicted byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pde_stream_checker
    import pde_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_wr_en,
    input  logic  i_cfg_wr_data,
    input  logic  i_in_valid,
    input  logic  i_in_stall,
    input  t_in   i_in_data,
    input  logic  i_out_valid,
    input  logic  i_out_stall,
    input  t_out  i_out_data,
    output int    o_errors,
    output int    o_pending,
    output int    o_items,
    output int    o_results
);

    t_phase     esc_phase;
    logic [7:0] held_byte;
    logic       entity_on;
    logic [7:0] step_bytes[$];
    t_out       decoded_q[$];
    int         errors;
    int         items_seen;
    int         results_seen;

    function automatic void put_byte(input logic [7:0] b);
        step_bytes = {step_bytes, b};
    endfunction

    function automatic bit hex_value(input logic [7:0] c, output logic [3:0] d);
        d = 4'd0;
        if (c >= "0" && c <= "9") begin
            d = c[3:0];
            return 1'b1;
        end
        // low nibble of 'a'..'f' and 'A'..'F' is 1..6
        if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
            d = c[3:0] + 4'd9;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void emit_decoded(input logic [7:0] v);
        if (!entity_on || v == CH_MINUS || v == CH_COMMA || v == CH_HASH) begin
            put_byte(v);
            return;
        end
        put_byte(CH_AMP);
        put_byte(CH_HASH);
        if (v >= 100)
            put_byte(8'(CH_ZERO + v / 100));
        if (v >= 10)
            put_byte(8'(CH_ZERO + (v / 10) % 10));
        put_byte(8'(CH_ZERO + v % 10));
        put_byte(CH_SEMI);
    endfunction

    function automatic void decode_item(input t_in item);
        logic [7:0] b;
        logic [7:0] held;
        logic [7:0] acc;
        logic [3:0] d;
        t_out       res;
        step_bytes = {};
        b = item.in_byte;
        case (esc_phase)
            PH_PCT: begin
                held_byte = b;
                esc_phase = PH_HELD;
            end
            PH_HELD: begin
                held = held_byte;
                acc = 8'd0;
                // v*16+d mod 256 keeps only the low nibble of v
                if (hex_value(held, d))
                    acc = {acc[3:0], d};
                if (hex_value(b, d))
                    acc = {acc[3:0], d};
                esc_phase = PH_IDLE;
                if (acc != 8'd0) begin
                    emit_decoded(acc);
                end else begin
                    put_byte(CH_PERCENT);
                    if (held == CH_PERCENT) begin
                        // held '%' opens a new escape around the second byte
                        held_byte = b;
                        esc_phase = PH_HELD;
                    end else begin
                        put_byte(held);
                        if (b == CH_PERCENT)
                            esc_phase = PH_PCT;
                        else
                            put_byte(b);
                    end
                end
            end
            default: begin
                esc_phase = PH_IDLE;
                if (b == CH_PERCENT)
                    esc_phase = PH_PCT;
                else
                    put_byte(b);
            end
        endcase
        if (item.in_last) begin
            // flush an unfinished escape literally
            if (esc_phase == PH_PCT) begin
                put_byte(CH_PERCENT);
            end else if (esc_phase == PH_HELD) begin
                put_byte(CH_PERCENT);
                put_byte(held_byte);
            end
            esc_phase = PH_IDLE;
            held_byte = 8'd0;
        end
        foreach (step_bytes[i]) begin
            res.out_byte = step_bytes[i];
            res.out_last = item.in_last && (i == step_bytes.size() - 1);
            decoded_q = {decoded_q, res};
        end
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            esc_phase = PH_IDLE;
            held_byte = 8'd0;
            entity_on = 1'b0;
            decoded_q = {};
            errors = 0;
            items_seen = 0;
            results_seen = 0;
        end else begin
            if (i_cfg_wr_en)
                entity_on = i_cfg_wr_data;
            if (i_in_valid && !i_in_stall) begin
                decode_item(i_in_data);
                items_seen++;
            end
            if (i_out_valid && !i_out_stall) begin
                results_seen++;
                if (decoded_q.size() == 0) begin
                    $display("%0t ns: unexpected output item, expected none,",
                             $time);
                    $display("    got byte %02h last %0b",
                             i_out_data.out_byte, i_out_data.out_last);
                    errors++;
                end else begin
                    want = decoded_q.pop_front();
                    if (i_out_data.out_byte !== want.out_byte ||
                        i_out_data.out_last !== want.out_last) begin
                        $display("%0t ns: mismatch, expected byte %02h last %0b,",
                                 $time, want.out_byte, want.out_last);
                        $display("    got byte %02h last %0b",
                                 i_out_data.out_byte, i_out_data.out_last);
                        errors++;
                    end
                end
            end
        end
        o_errors  <= errors;
        o_pending <= decoded_q.size();
        o_items   <= items_seen;
        o_results <= results_seen;
    end

endmodule

// ===== verif/percent_escape_decoder_top_tb.sv =====
// ----------------------------------------------------------------------------
// percent_escape_decoder_top_tb: stream test of the percent escape decoder
// Sends directed and random escaped strings in raw and entity mode, with
// random gaps on the input and random stalls on the output, and lets the
// stream checker score every decoded byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module percent_escape_decoder_top_tb;
    import pde_pkg::*;

    localparam int DRAIN_CYCLES = 16;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_in        in_data = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out       out_data;
    logic       gaps_on = 1'b1;
    logic [7:0] text_q[$];
    int         bytes_sent = 0;
    int         errors;
    int         pending;
    int         items_seen;
    int         results_seen;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    percent_escape_decoder_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_valid       (in_valid),
        .o_stall       (in_stall),
        .i_data        (in_data),
        .o_valid       (out_valid),
        .i_stall       (out_stall),
        .o_data        (out_data)
    );

    pde_stream_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_items       (items_seen),
        .o_results     (results_seen)
    );

    always @(posedge i_clk) begin
        out_stall <= gaps_on && ($urandom_range(99) < 27);
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        // while gaps are on, stay idle as long as each draw, at the same odds, calls for a gap
        while (gaps_on && $urandom_range(99) < 27) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{in_byte: b, in_last: last};
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], i == s.len() - 1);
    endtask

    // hold the input and wait until every decoded byte is out
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic entity);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= entity;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
            return 8'(CH_ZERO + v);
        return 8'((($urandom_range(1) != 0) ? "a" : "A") + v - 4'd10);
    endfunction

    function automatic void add_char(input logic [7:0] c);
        text_q = {text_q, c};
    endfunction

    task automatic send_random_text();
        int         n_chunks;
        int         kind;
        logic [7:0] v;
        text_q = {};
        n_chunks = $urandom_range(1, 6);
        repeat (n_chunks) begin
            kind = $urandom_range(99);
            if (kind < 45) begin
                v = 8'($urandom_range(255));
                if ($urandom_range(7) == 0) begin
                    case ($urandom_range(3))
                        0: v = CH_MINUS;
                        1: v = CH_COMMA;
                        2: v = CH_HASH;
                        default: v = CH_PERCENT;
                    endcase
                end
                add_char(CH_PERCENT);
                add_char(hex_char(v[7:4]));
                add_char(hex_char(v[3:0]));
            end else if (kind < 65) begin
                add_char(8'($urandom_range(255)));
            end else if (kind < 75) begin
                // escapes that decode to zero and get rescanned
                add_char(CH_PERCENT);
                case ($urandom_range(2))
                    0: begin
                        add_char(hex_char(4'd0));
                        add_char(hex_char(4'd0));
                    end
                    1: begin
                        add_char(CH_PERCENT);
                        add_char(($urandom_range(1) != 0) ? "z" : "0");
                    end
                    default: begin
                        add_char(hex_char(4'd0));
                        add_char(CH_PERCENT);
                    end
                endcase
            end else if (kind < 87) begin
                add_char(CH_PERCENT);
                add_char(8'($urandom_range(255)));
                add_char(8'($urandom_range(255)));
            end else begin
                add_char(8'($urandom_range(32, 126)));
            end
        end
        // sometimes end the string inside an escape
        if ($urandom_range(9) == 0) begin
            add_char(CH_PERCENT);
            if ($urandom_range(1) != 0)
                add_char(hex_char(4'($urandom_range(15))));
        end
        foreach (text_q[i])
            send_byte(text_q[i], i == text_q.size() - 1);
    endtask

    task automatic random_phase(input int n_bytes);
        int first;
        first = bytes_sent;
        while (bytes_sent - first < n_bytes)
            send_random_text();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_mode(1'b0);
        send_text("%4a");
        send_text("%%zz");
        send_text("%25");
        send_text("%g1");
        send_text("%4");
        send_text("%");
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);

        write_mode(1'b1);
        send_text("%2c%Ff%0%");

        write_mode(1'b0);
        random_phase(85);
        write_mode(1'b1);
        random_phase(95);

        // back-to-back stretch: no input gaps, no output stalls
        gaps_on <= 1'b0;
        random_phase(85);
        gaps_on <= 1'b1;

        drain();
        $display("covered %0d input items and %0d decoded output items", items_seen,
                 results_seen);
        $display("raw and entity modes, zero and broken escapes, cut strings, gaps, stalls");
        if (errors == 0 && pending == 0) begin
            $display("percent_escape_decoder_top_tb: PASS");
        end else begin
            $display("percent_escape_decoder_top_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("timeout with %0d output items outstanding", pending);
        $display("percent_escape_decoder_top_tb: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/pde_pkg.sv
hdl/pde_decode.sv
hdl/percent_escape_decoder_top.sv
verif/pde_stream_checker.sv
verif/percent_escape_decoder_top_tb.sv
